// File: design/betp_pkg.sv
// package for the board eeprom tlv parser
// record kinds, error codes, phases and parameter defaults; no dependencies
package betp_pkg;
    localparam int IMAGE_BYTES_DEF = 256;
    localparam int ASSEMBLY_LEN_DEF = 12;
    localparam int SKU_CAP = 10;

    localparam logic [2:0] KIND_TEXT = 3'd0;
    localparam logic [2:0] KIND_SKU = 3'd1;
    localparam logic [2:0] KIND_MAC = 3'd2;
    localparam logic [2:0] KIND_REV = 3'd3;
    localparam logic [2:0] KIND_PROD = 3'd4;
    localparam logic [2:0] KIND_DONE = 3'd5;
    localparam logic [2:0] KIND_FAIL = 3'd6;

    localparam logic [2:0] SID_PCA = 3'd0;
    localparam logic [2:0] SID_SERIAL = 3'd1;
    localparam logic [2:0] SID_MFG = 3'd2;
    localparam logic [2:0] SID_ASY = 3'd3;
    localparam logic [2:0] SID_SKU = 3'd4;

    localparam logic [1:0] ERR_HEADER = 2'd0;
    localparam logic [1:0] ERR_FORMAT = 2'd1;
    localparam logic [1:0] ERR_HEX = 2'd2;

    localparam logic [7:0] TYPE_END = 8'h00;
    localparam logic [7:0] TYPE_MFG = 8'h02;
    localparam logic [7:0] TYPE_SKU = 8'h03;
    localparam logic [7:0] TYPE_ASY = 8'h04;
    localparam logic [7:0] TYPE_MAC = 8'h05;
    localparam logic [7:0] TYPE_REV = 8'h0B;
    localparam logic [7:0] TYPE_SERIAL = 8'h0E;
    localparam logic [7:0] TYPE_MFG2 = 8'h17;

    localparam logic [1:0] PH_FIXED = 2'd0;
    localparam logic [1:0] PH_TYPE = 2'd1;
    localparam logic [1:0] PH_LEN = 2'd2;
    localparam logic [1:0] PH_DATA = 2'd3;

    typedef struct packed {
        logic [2:0] record_kind;
        logic [2:0] string_id;
        logic [3:0] char_index;
        logic [7:0] char_value;
        logic [47:0] mac_value;
        logic [7:0] rev_major;
        logic [7:0] rev_minor;
        logic production;
        logic [1:0] error_code;
    } rec_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic first_byte;
    } req_t;

    function automatic logic [4:0] hexval(input logic [7:0] c);
        logic [4:0] v;
        v = 5'd16;
        if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
        else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
        else if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
        return v;
    endfunction

    function automatic rec_t mk(input logic [2:0] kind);
        rec_t r;
        r = '0;
        r.record_kind = kind;
        return r;
    endfunction
endpackage

// File: design/betp_if.sv
// valid/ready channel interfaces for requests and result records
// no dependencies
interface betp_req_if;
    logic valid;
    logic ready;
    logic [7:0] data_byte;
    logic first_byte;
    modport source (output valid, data_byte, first_byte, input ready);
    modport sink (input valid, data_byte, first_byte, output ready);
endinterface

interface betp_rec_if;
    logic valid;
    logic ready;
    logic [2:0] record_kind;
    logic [2:0] string_id;
    logic [3:0] char_index;
    logic [7:0] char_value;
    logic [47:0] mac_value;
    logic [7:0] rev_major;
    logic [7:0] rev_minor;
    logic production;
    logic [1:0] error_code;
    modport source (output valid, record_kind, string_id, char_index, char_value,
        mac_value, rev_major, rev_minor, production, error_code, input ready);
    modport sink (input valid, record_kind, string_id, char_index, char_value,
        mac_value, rev_major, rev_minor, production, error_code, output ready);
endinterface

// File: design/board_eeprom_tlv_parser.sv
// a request is registered and processed combinationally; its records are
// written into a four-entry output queue register, which presents them
// throughput: one byte per cycle while the queue has room for two records
// reset: parser idle until a first_byte request, sku_max_chars reads 10
// depends on betp_pkg, betp_if and betp_core
module board_eeprom_tlv_parser #(
    parameter int IMAGE_BYTES = betp_pkg::IMAGE_BYTES_DEF,
    parameter int ASSEMBLY_LEN = betp_pkg::ASSEMBLY_LEN_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic cfg_we,
    input  logic [3:0] cfg_wdata,
    betp_req_if.sink in_req,
    betp_rec_if.source out_rec
);
    logic [3:0] sku_reg;
    logic req_valid_reg;
    betp_pkg::req_t req_reg;
    logic [1:0] cnt;
    betp_pkg::rec_t r0, r1;
    betp_pkg::rec_t q_reg [4];
    logic [1:0] rd_reg, wr_reg;
    logic [2:0] fill_reg, fill_next;
    logic pop;
    logic [2:0] pending;

    assign pending = fill_reg + (req_valid_reg ? 3'd2 : 3'd0);
    assign in_req.ready = (pending <= 3'd2) || (pending == 3'd3 && pop);
    assign pop = out_rec.valid && out_rec.ready;
    assign out_rec.valid = fill_reg != 3'd0;
    assign out_rec.record_kind = q_reg[rd_reg].record_kind;
    assign out_rec.string_id = q_reg[rd_reg].string_id;
    assign out_rec.char_index = q_reg[rd_reg].char_index;
    assign out_rec.char_value = q_reg[rd_reg].char_value;
    assign out_rec.mac_value = q_reg[rd_reg].mac_value;
    assign out_rec.rev_major = q_reg[rd_reg].rev_major;
    assign out_rec.rev_minor = q_reg[rd_reg].rev_minor;
    assign out_rec.production = q_reg[rd_reg].production;
    assign out_rec.error_code = q_reg[rd_reg].error_code;

    betp_core #(.IMAGE_BYTES(IMAGE_BYTES), .ASSEMBLY_LEN(ASSEMBLY_LEN)) u_core (
        .clk(clk), .rst_n(rst_n), .step(req_valid_reg), .req(req_reg),
        .sku_max_chars(sku_reg), .rec_count(cnt), .rec0(r0), .rec1(r1));

    assign fill_next = fill_reg + 3'(cnt) - (pop ? 3'd1 : 3'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sku_reg <= 4'd10; req_valid_reg <= 1'b0;
            rd_reg <= '0; wr_reg <= '0; fill_reg <= '0;
        end
        else
        begin
            if (cfg_we) sku_reg <= cfg_wdata;
            req_valid_reg <= in_req.valid && in_req.ready;
            if (pop) rd_reg <= rd_reg + 2'd1;
            wr_reg <= wr_reg + cnt;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_req.valid && in_req.ready)
        begin
            req_reg.data_byte <= in_req.data_byte;
            req_reg.first_byte <= in_req.first_byte;
        end
        if (cnt != 2'd0) q_reg[wr_reg] <= r0;
        if (cnt == 2'd2) q_reg[wr_reg + 2'd1] <= r1;
    end

    a_fill: assert property (@(posedge clk) disable iff (!rst_n) fill_reg <= 3'd4)
        else $error("record queue overflow");
    a_room: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid_reg |-> fill_reg <= 3'd3)
        else $error("request issued without queue room");
    a_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg == 3'd0 && cnt == 2'd0) |=> !out_rec.valid)
        else $error("record shown from empty queue");
endmodule

// File: design/betp_core.sv
// parser state and per-byte logic; one registered request in, up to two records out
// depends on betp_pkg
module betp_core #(
    parameter int IMAGE_BYTES = betp_pkg::IMAGE_BYTES_DEF,
    parameter int ASSEMBLY_LEN = betp_pkg::ASSEMBLY_LEN_DEF
) (
    input  logic clk,
    input  logic rst_n,
    input  logic step,
    input  betp_pkg::req_t req,
    input  logic [3:0] sku_max_chars,
    output logic [1:0] rec_count,
    output betp_pkg::rec_t rec0,
    output betp_pkg::rec_t rec1
);
    localparam int PW = $clog2(IMAGE_BYTES + 1);

    logic [PW-1:0] pos_reg, pos_next;
    logic [1:0] phase_reg, phase_next;
    logic [15:0] acc_reg, acc_next;
    logic [7:0] type_reg, type_next;
    logic [15:0] left_reg, left_next;
    logic mfg2_reg, mfg2_next;
    logic [7:0] sku_reg [betp_pkg::SKU_CAP], sku_next [betp_pkg::SKU_CAP];
    logic [47:0] mac_reg, mac_next;
    logic [7:0] run_reg, run_next, saved_reg, saved_next, after_reg, after_next;
    logic dot_reg, dot_next, alpha_reg, alpha_next;
    logic ok_reg, ok_next, stop_reg, stop_next, pend_reg, pend_next;
    logic [2:0] dig_reg, dig_next;
    logic [15:0] fpos_reg, fpos_next;

    logic [3:0] lim;
    assign lim = (sku_max_chars > 4'(betp_pkg::SKU_CAP)) ? 4'(betp_pkg::SKU_CAP)
                                                         : sku_max_chars;

    function automatic logic sku_match(input logic [7:0] s [betp_pkg::SKU_CAP],
                                       input logic [79:0] p, input int n);
        logic m;
        m = 1'b1;
        for (int i = 0; i < 10; i++)
            if (i < n && s[i] != p[79-8*i -: 8]) m = 1'b0;
        return m;
    endfunction

    always_comb
    begin
        logic [7:0] c;
        logic [4:0] d;
        logic [3:0] kept;
        logic run;
        logic fin;
        logic [3:0] done;
        logic [47:0] m;
        logic [7:0] b;
        logic [15:0] acc_sh;
        betp_pkg::rec_t r [2];
        int n;
        c = req.data_byte;
        n = 0;
        r[0] = '0;
        r[1] = '0;
        fin = 1'b0;
        pos_next = pos_reg; phase_next = phase_reg; acc_next = acc_reg;
        type_next = type_reg; left_next = left_reg; mfg2_next = mfg2_reg;
        sku_next = sku_reg; mac_next = mac_reg; run_next = run_reg;
        saved_next = saved_reg; after_next = after_reg; dot_next = dot_reg;
        alpha_next = alpha_reg; ok_next = ok_reg; stop_next = stop_reg;
        pend_next = pend_reg; dig_next = dig_reg; fpos_next = fpos_reg;
        run = 1'b0;
        kept = '0; done = '0; m = '0; b = '0; d = '0; acc_sh = '0;
        if (step)
        begin
            if (req.first_byte)
            begin
                if (pend_reg)
                begin
                    r[0] = betp_pkg::mk(betp_pkg::KIND_DONE);
                    n = 1;
                end
                pos_next = '0; phase_next = betp_pkg::PH_FIXED; type_next = '0;
                left_next = '0; mfg2_next = 1'b0; ok_next = 1'b1; stop_next = 1'b0;
                pend_next = 1'b0; dig_next = '0;
                fpos_next = '0; run_next = '0; saved_next = '0; after_next = '0;
                dot_next = 1'b0; mac_next = '0; acc_next = '0; alpha_next = 1'b0;
                for (int i = 0; i < betp_pkg::SKU_CAP; i++) sku_next[i] = '0;
                run = 1'b1;
            end
            else if (stop_reg)
            begin
                if (pend_reg)
                begin
                    pend_next = 1'b0;
                    r[0] = betp_pkg::mk(betp_pkg::KIND_DONE);
                    n = 1;
                end
            end
            else
                run = 1'b1;
        end
        if (run)
        begin
            if (phase_next == betp_pkg::PH_FIXED)
            begin
                if (pos_next < PW'(4))
                begin
                    if (c != ((pos_next == PW'(3)) ? 8'h03 : 8'h00)) ok_next = 1'b0;
                    if (pos_next == PW'(3))
                    begin
                        if (!ok_next)
                        begin
                            r[n] = betp_pkg::mk(betp_pkg::KIND_FAIL);
                            r[n].error_code = betp_pkg::ERR_HEADER;
                            n++; stop_next = 1'b1; fin = 1'b1;
                        end
                        ok_next = 1'b1;
                    end
                end
                else if (pos_next >= PW'(8) && pos_next < PW'(12))
                begin
                    if (c != ((pos_next == PW'(11)) ? 8'h32 : 8'h30)) ok_next = 1'b0;
                    if (pos_next == PW'(11))
                    begin
                        if (!ok_next)
                        begin
                            r[n] = betp_pkg::mk(betp_pkg::KIND_FAIL);
                            r[n].error_code = betp_pkg::ERR_FORMAT;
                            n++; stop_next = 1'b1; fin = 1'b1;
                        end
                        ok_next = 1'b1;
                    end
                end
                else if (pos_next >= PW'(12) && pos_next < PW'(35))
                begin
                    r[n] = betp_pkg::mk(betp_pkg::KIND_TEXT);
                    r[n].string_id = (pos_next < PW'(24)) ? betp_pkg::SID_PCA
                                                          : betp_pkg::SID_SERIAL;
                    r[n].char_index = (pos_next < PW'(24)) ? 4'(pos_next - PW'(12))
                                                           : 4'(pos_next - PW'(24));
                    r[n].char_value = c;
                    n++;
                end
                else if (pos_next == PW'(37))
                begin
                    phase_next = betp_pkg::PH_TYPE; dig_next = '0; acc_next = '0;
                end
            end
            else if (phase_next != betp_pkg::PH_DATA)
            begin
                d = betp_pkg::hexval(c);
                if (d[4])
                begin
                    r[n] = betp_pkg::mk(betp_pkg::KIND_FAIL);
                    r[n].error_code = betp_pkg::ERR_HEX;
                    n++; stop_next = 1'b1; fin = 1'b1;
                end
                else
                begin
                    acc_sh = {acc_next[11:0], d[3:0]};
                    acc_next = acc_sh;
                    dig_next = dig_next + 3'd1;
                    if (phase_next == betp_pkg::PH_TYPE && dig_next == 3'd2)
                    begin
                        type_next = acc_sh[7:0]; phase_next = betp_pkg::PH_LEN;
                        dig_next = '0; acc_next = '0;
                    end
                    else if (phase_next == betp_pkg::PH_LEN && dig_next == 3'd4)
                    begin
                        if (type_next == betp_pkg::TYPE_END)
                        begin
                            r[n] = betp_pkg::mk(betp_pkg::KIND_DONE);
                            n++; stop_next = 1'b1; fin = 1'b1;
                        end
                        else
                        begin
                            fpos_next = '0; run_next = '0; saved_next = '0;
                            after_next = '0; dot_next = 1'b0; mac_next = '0;
                            acc_next = '0; alpha_next = 1'b0;
                            for (int i = 0; i < betp_pkg::SKU_CAP; i++) sku_next[i] = '0;
                            if (type_next == betp_pkg::TYPE_MFG2) mfg2_next = 1'b1;
                            left_next = acc_sh; dig_next = '0;
                            phase_next = (acc_sh == 16'd0) ? betp_pkg::PH_TYPE
                                                           : betp_pkg::PH_DATA;
                        end
                    end
                end
            end
            else
            begin
                unique case (type_next)
                    betp_pkg::TYPE_MFG, betp_pkg::TYPE_MFG2:
                        if ((type_next == betp_pkg::TYPE_MFG2 || !mfg2_next)
                            && fpos_next < 16'd10)
                        begin
                            r[n] = betp_pkg::mk(betp_pkg::KIND_TEXT);
                            r[n].string_id = betp_pkg::SID_MFG;
                            r[n].char_index = fpos_next[3:0]; r[n].char_value = c; n++;
                        end
                    betp_pkg::TYPE_SERIAL:
                        if (fpos_next < 16'd11)
                        begin
                            r[n] = betp_pkg::mk(betp_pkg::KIND_TEXT);
                            r[n].string_id = betp_pkg::SID_SERIAL;
                            r[n].char_index = fpos_next[3:0]; r[n].char_value = c; n++;
                        end
                    betp_pkg::TYPE_ASY:
                        if (fpos_next < 16'(ASSEMBLY_LEN))
                        begin
                            r[n] = betp_pkg::mk(betp_pkg::KIND_TEXT);
                            r[n].string_id = betp_pkg::SID_ASY;
                            r[n].char_index = fpos_next[3:0]; r[n].char_value = c; n++;
                            if ((fpos_next + 16'd2 == 16'(ASSEMBLY_LEN) ||
                                 fpos_next + 16'd1 == 16'(ASSEMBLY_LEN)) &&
                                ((c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A)))
                                alpha_next = 1'b1;
                        end
                    betp_pkg::TYPE_SKU:
                        if (fpos_next < 16'(lim))
                        begin
                            r[n] = betp_pkg::mk(betp_pkg::KIND_TEXT);
                            r[n].string_id = betp_pkg::SID_SKU;
                            r[n].char_index = fpos_next[3:0]; r[n].char_value = c; n++;
                            sku_next[fpos_next[3:0]] = c;
                        end
                    betp_pkg::TYPE_MAC:
                        if (fpos_next < 16'd12)
                        begin
                            d = betp_pkg::hexval(c);
                            if (!fpos_next[0]) acc_next = 16'(d);
                            else
                            begin
                                b = (acc_next < 16'd16 && !d[4]) ?
                                    {acc_next[3:0], d[3:0]} : 8'hFF;
                                mac_next = {mac_next[39:0], b};
                            end
                        end
                    betp_pkg::TYPE_REV:
                        if (c == 8'h2E)
                        begin
                            saved_next = run_next; dot_next = 1'b1; after_next = '0;
                            run_next = 8'(run_next * 8'd10);
                        end
                        else
                        begin
                            d = betp_pkg::hexval(c);
                            if (d[4]) d = '0;
                            run_next = 8'(run_next * 8'd10 + 8'(d));
                            after_next = 8'(after_next * 8'd10 + 8'(d));
                        end
                    default: ;
                endcase
                fpos_next = fpos_next + 16'd1;
                left_next = left_next - 16'd1;
                if (left_next == 16'd0)
                begin
                    phase_next = betp_pkg::PH_TYPE; dig_next = '0;
                end
            end
            if (!fin && left_next == 16'd0 && phase_next == betp_pkg::PH_TYPE &&
                ((phase_reg == betp_pkg::PH_DATA && !req.first_byte) ||
                 (dig_reg == 3'd3 && phase_reg == betp_pkg::PH_LEN && !req.first_byte &&
                  dig_next == 3'd0)))
            begin
                unique case (type_next)
                    betp_pkg::TYPE_SKU:
                    begin
                        kept = '0;
                        for (int i = 0; i < betp_pkg::SKU_CAP; i++)
                            if (kept == 4'(i) && 4'(i) < lim && sku_next[i] != 8'd0)
                                kept = kept + 4'd1;
                        if (kept >= 4'd10 && sku_match(sku_next, 80'h373338382D3136434432, 10))
                            kept = 4'd10;
                        else if (kept >= 4'd9 &&
                                 sku_match(sku_next, 80'h373338382D3136434400, 9))
                            kept = 4'd9;
                        else if (kept >= 4'd7 &&
                                 sku_match(sku_next, 80'h373338382D3844000000, 7))
                            kept = 4'd7;
                        r[n] = betp_pkg::mk(betp_pkg::KIND_SKU);
                        r[n].string_id = betp_pkg::SID_SKU; r[n].char_index = kept; n++;
                    end
                    betp_pkg::TYPE_ASY:
                    begin
                        r[n] = betp_pkg::mk(betp_pkg::KIND_PROD);
                        r[n].string_id = betp_pkg::SID_ASY; r[n].production = alpha_next;
                        n++;
                    end
                    betp_pkg::TYPE_MAC:
                    begin
                        done = (fpos_next < 16'd12) ? {1'b0, fpos_next[3:1]} : 4'd6;
                        m = mac_next;
                        for (int i = 0; i < 6; i++)
                            if (4'(i) >= done) m = {m[39:0], 8'hFF};
                        mac_next = m;
                        r[n] = betp_pkg::mk(betp_pkg::KIND_MAC);
                        r[n].mac_value = m; n++;
                    end
                    betp_pkg::TYPE_REV:
                    begin
                        r[n] = betp_pkg::mk(betp_pkg::KIND_REV);
                        r[n].rev_major = dot_next ? saved_next : run_next;
                        r[n].rev_minor = dot_next ? after_next : 8'd0;
                        n++;
                    end
                    default: ;
                endcase
                acc_next = '0;
            end
            if (!fin)
            begin
                pos_next = pos_next + PW'(1);
                if (pos_next >= PW'(IMAGE_BYTES))
                begin
                    stop_next = 1'b1; pend_next = 1'b1;
                end
            end
        end
        rec0 = r[0];
        rec1 = r[1];
        rec_count = 2'(n);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0; phase_reg <= betp_pkg::PH_FIXED; acc_reg <= '0; type_reg <= '0;
            left_reg <= '0; mfg2_reg <= 1'b0; mac_reg <= '0; run_reg <= '0;
            saved_reg <= '0; after_reg <= '0; dot_reg <= 1'b0; alpha_reg <= 1'b0;
            ok_reg <= 1'b1; stop_reg <= 1'b1; pend_reg <= 1'b0; dig_reg <= '0;
            fpos_reg <= '0;
            for (int i = 0; i < betp_pkg::SKU_CAP; i++) sku_reg[i] <= '0;
        end
        else
        begin
            pos_reg <= pos_next; phase_reg <= phase_next; acc_reg <= acc_next;
            type_reg <= type_next; left_reg <= left_next; mfg2_reg <= mfg2_next;
            mac_reg <= mac_next; run_reg <= run_next; saved_reg <= saved_next;
            after_reg <= after_next; dot_reg <= dot_next; alpha_reg <= alpha_next;
            ok_reg <= ok_next; stop_reg <= stop_next; pend_reg <= pend_next;
            dig_reg <= dig_next; fpos_reg <= fpos_next; sku_reg <= sku_next;
        end
    end
endmodule
